### rtl/vrp_pkg.sv
// Shared types and constants for the vertex rotate and project block.
`timescale 1ns / 1ps
package vrp_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    // Rotated coordinate width, product width and divider remainder width
    localparam int RW = 32;
    localparam int PW = 48;
    localparam int MW = 56;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_BITS    = 24;

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = -24'sh800000;

    typedef enum logic [2:0] {
        REG_CAM_X   = 3'd0,
        REG_CAM_Y   = 3'd1,
        REG_CAM_Z   = 3'd2,
        REG_FOCAL   = 3'd3,
        REG_YAW     = 3'd4,
        REG_PITCH   = 3'd5,
        REG_ROLL    = 3'd6
    } vrp_reg_t;

    // One classified vertex handed from the front to the back
    typedef struct packed {
        logic                 last;
        logic                 neg;
        logic signed [RW-1:0] z;
        logic signed [PW-1:0] numx;
        logic signed [PW-1:0] numy;
    } vrp_entry_t;

endpackage

### rtl/vrp_front.sv
// Front: config registers, camera offset, three rotations and numerators.
`timescale 1ns / 1ps
module vrp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [2:0]              cfg_addr,
    input  logic [31:0]             cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic signed [23:0]      vert_x,
    input  logic signed [23:0]      vert_y,
    input  logic signed [23:0]      vert_z,
    input  logic                    last_in,
    input  logic                    q_full,
    output logic                    q_push,
    output vrp_pkg::vrp_entry_t     q_data
);
    import vrp_pkg::*;

    logic signed [23:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [15:0]        focal_reg;
    logic [31:0]        yaw_reg, pitch_reg, roll_reg;

    logic [7:0] vld_reg;
    logic       en;

    logic signed [24:0]   dx_reg, dy_reg, dz_reg;
    logic [7:0]           last_reg;
    logic signed [PW-1:0] p1a_reg, p1b_reg, p1c_reg, p1d_reg;
    logic signed [RW-1:0] y1_reg;
    logic signed [RW-1:0] x2_reg, y2_reg, z2_reg;
    logic signed [PW-1:0] p3a_reg, p3b_reg, p3c_reg, p3d_reg;
    logic signed [RW-1:0] x3_reg;
    logic signed [RW-1:0] x4_reg, y4_reg, z4_reg;
    logic signed [PW-1:0] p5a_reg, p5b_reg, p5c_reg, p5d_reg;
    logic signed [RW-1:0] z5_reg;
    logic signed [RW-1:0] x6_reg, y6_reg, z6_reg;
    vrp_entry_t           ent_reg;

    // round half up from Q.22 to Q.8
    function automatic logic signed [RW-1:0] rnd14(input logic signed [PW:0] s);
        logic signed [PW:0] t;
        t = s + (PW+1)'(8192);
        return t[RW+13:14];
    endfunction

    assign en     = !vld_reg[7] || !q_full;
    assign full   = !en;
    assign q_push = vld_reg[7] && !q_full;
    assign q_data = ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            focal_reg <= 16'd500;
            yaw_reg   <= 32'h4000_0000;
            pitch_reg <= 32'h4000_0000;
            roll_reg  <= 32'h4000_0000;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CAM_X: cam_x_reg <= cfg_wdata[23:0];
                REG_CAM_Y: cam_y_reg <= cfg_wdata[23:0];
                REG_CAM_Z: cam_z_reg <= cfg_wdata[23:0];
                REG_FOCAL: focal_reg <= cfg_wdata[15:0];
                REG_YAW:   yaw_reg   <= cfg_wdata;
                REG_PITCH: pitch_reg <= cfg_wdata;
                REG_ROLL:  roll_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[6:0], push};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= {last_reg[6:0], last_in};
            dx_reg   <= 25'(vert_x) - 25'(cam_x_reg);
            dy_reg   <= 25'(vert_y) - 25'(cam_y_reg);
            dz_reg   <= 25'(vert_z) - 25'(cam_z_reg);
            // yaw on x,z
            p1a_reg  <= RW'(dx_reg) * $signed(yaw_reg[31:16]);
            p1b_reg  <= RW'(dz_reg) * $signed(yaw_reg[15:0]);
            p1c_reg  <= RW'(dx_reg) * $signed(yaw_reg[15:0]);
            p1d_reg  <= RW'(dz_reg) * $signed(yaw_reg[31:16]);
            y1_reg   <= RW'(dy_reg);
            x2_reg   <= rnd14((PW+1)'(p1a_reg) - (PW+1)'(p1b_reg));
            z2_reg   <= rnd14((PW+1)'(p1c_reg) + (PW+1)'(p1d_reg));
            y2_reg   <= y1_reg;
            // pitch on y,z
            p3a_reg  <= y2_reg * $signed(pitch_reg[31:16]);
            p3b_reg  <= z2_reg * $signed(pitch_reg[15:0]);
            p3c_reg  <= y2_reg * $signed(pitch_reg[15:0]);
            p3d_reg  <= z2_reg * $signed(pitch_reg[31:16]);
            x3_reg   <= x2_reg;
            y4_reg   <= rnd14((PW+1)'(p3a_reg) - (PW+1)'(p3b_reg));
            z4_reg   <= rnd14((PW+1)'(p3c_reg) + (PW+1)'(p3d_reg));
            x4_reg   <= x3_reg;
            // roll on x,y
            p5a_reg  <= x4_reg * $signed(roll_reg[31:16]);
            p5b_reg  <= y4_reg * $signed(roll_reg[15:0]);
            p5c_reg  <= x4_reg * $signed(roll_reg[15:0]);
            p5d_reg  <= y4_reg * $signed(roll_reg[31:16]);
            z5_reg   <= z4_reg;
            x6_reg   <= rnd14((PW+1)'(p5a_reg) - (PW+1)'(p5b_reg));
            y6_reg   <= rnd14((PW+1)'(p5c_reg) + (PW+1)'(p5d_reg));
            z6_reg   <= z5_reg;
            // classify and form numerators
            ent_reg.last <= last_reg[6];
            ent_reg.neg  <= z6_reg[RW-1];
            ent_reg.z    <= z6_reg;
            ent_reg.numx <= $signed({1'b0, focal_reg}) * x6_reg;
            ent_reg.numy <= $signed({1'b0, focal_reg}) * y6_reg;
        end
    end

endmodule

### rtl/vrp_queue.sv
// Short queue between front and back.
`timescale 1ns / 1ps
module vrp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vrp_pkg::vrp_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output vrp_pkg::vrp_entry_t pop_data,
    output logic                empty
);
    import vrp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    vrp_entry_t     mem [QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    count_reg;

    assign full     = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(QUEUE_DEPTH))
        else $error("queue count over depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule

### rtl/vrp_back.sv
// Back: pipelined divide, saturation, screen offset and visibility.
`timescale 1ns / 1ps
module vrp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  vrp_pkg::vrp_entry_t     q_data,
    output logic                    q_pop,
    input  logic                    pop,
    output logic                    empty,
    output logic signed [23:0]      screen_x,
    output logic signed [23:0]      screen_y,
    output logic signed [23:0]      depth,
    output logic                    visible,
    output logic                    last_out
);
    import vrp_pkg::*;

    localparam int NS = DIV_BITS + 2;

    typedef struct packed {
        logic          sign;
        logic          ovf;
        logic [MW-1:0] r;
        logic [23:0]   q;
    } div_t;

    typedef struct packed {
        logic                 last;
        logic                 neg;
        logic signed [RW-1:0] z;
        div_t                 dx;
        div_t                 dy;
    } bk_t;

    bk_t               pipe_reg [NS];
    bk_t               pipe_next [NS];
    logic [NS-1:0]     vld_reg;
    logic              qv_reg, ov_reg, en;
    logic              qlast_reg, qneg_reg;
    logic signed [RW-1:0] qz_reg;
    logic signed [23:0] qx_reg, qy_reg;
    logic signed [25:0] tx, ty;
    logic signed [23:0] sx, sy;

    function automatic div_t load(input logic signed [PW-1:0] n);
        div_t d;
        logic [PW-1:0] a;
        a      = n[PW-1] ? PW'(-n) : PW'(n);
        d.sign = n[PW-1];
        d.ovf  = 1'b0;
        d.r    = {a, 8'b0};
        d.q    = '0;
        return d;
    endfunction

    function automatic div_t ovf_chk(input div_t d, input logic [MW-1:0] zu);
        div_t o;
        o     = d;
        o.ovf = (d.r >= (zu << DIV_BITS)) && (d.r != '0);
        return o;
    endfunction

    // zero divisor never sets a quotient bit, so 0 / 0 stays 0
    function automatic div_t step(input div_t d, input logic [MW-1:0] zs, input int b);
        div_t o;
        o = d;
        if ((d.r >= zs) && (zs != '0))
        begin
            o.r    = d.r - zs;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

    function automatic logic signed [23:0] qsat(input div_t d);
        logic signed [23:0] v;
        if (d.ovf)
            v = d.sign ? Q_MIN : Q_MAX;
        else if (!d.sign)
            v = d.q[23] ? Q_MAX : $signed(d.q);
        else
            v = d.q[23] ? Q_MIN : $signed(24'(-d.q));
        return v;
    endfunction

    function automatic logic signed [23:0] sat_hi(input logic signed [25:0] t);
        return (t > 26'(Q_MAX)) ? Q_MAX : t[23:0];
    endfunction

    assign en    = !ov_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !ov_reg;

    always_comb
    begin
        logic [MW-1:0] zu;
        pipe_next[0].last = q_data.last;
        pipe_next[0].neg  = q_data.neg;
        pipe_next[0].z    = q_data.z;
        pipe_next[0].dx   = load(q_data.numx);
        pipe_next[0].dy   = load(q_data.numy);
        zu = MW'($unsigned(pipe_reg[0].z));
        pipe_next[1]    = pipe_reg[0];
        pipe_next[1].dx = ovf_chk(pipe_reg[0].dx, zu);
        pipe_next[1].dy = ovf_chk(pipe_reg[0].dy, zu);
        for (int k = 0; k < DIV_BITS; k++)
        begin
            zu = MW'($unsigned(pipe_reg[k+1].z)) << (DIV_BITS - 1 - k);
            pipe_next[k+2]    = pipe_reg[k+1];
            pipe_next[k+2].dx = step(pipe_reg[k+1].dx, zu, DIV_BITS - 1 - k);
            pipe_next[k+2].dy = step(pipe_reg[k+1].dy, zu, DIV_BITS - 1 - k);
        end
    end

    assign tx = 26'(SCREEN_WIDTH * 128) - 26'(qx_reg);
    assign ty = 26'(SCREEN_HEIGHT * 128) - 26'(qy_reg);
    assign sx = sat_hi(tx);
    assign sy = sat_hi(ty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], !q_empty};
            qv_reg  <= vld_reg[NS-1];
            ov_reg  <= qv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
                pipe_reg[k] <= pipe_next[k];
            qlast_reg <= pipe_reg[NS-1].last;
            qneg_reg  <= pipe_reg[NS-1].neg;
            qz_reg    <= pipe_reg[NS-1].z;
            qx_reg    <= qsat(pipe_reg[NS-1].dx);
            qy_reg    <= qsat(pipe_reg[NS-1].dy);
            last_out  <= qlast_reg;
            if (qneg_reg)
            begin
                screen_x <= '0;
                screen_y <= '0;
                depth    <= '0;
                visible  <= 1'b0;
            end
            else
            begin
                screen_x <= sx;
                screen_y <= sy;
                depth    <= (qz_reg > RW'(Q_MAX)) ? Q_MAX : qz_reg[23:0];
                visible  <= !(((sx > 24'(SCREEN_WIDTH * 256)) || sx[23]) &&
                              ((sy > 24'(SCREEN_HEIGHT * 256)) || sy[23]));
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> en)
        else $error("queue read while back stalled");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !pop) |=> ov_reg && $stable(screen_x) && $stable(depth))
        else $error("result changed while stalled");
    a_neg_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        (en && qv_reg && qneg_reg) |=> !visible)
        else $error("vertex behind camera marked visible");
`endif

endmodule

### rtl/vertex_rotate_perspective_project.sv
// Top level of the vertex rotate and perspective project block.
`timescale 1ns / 1ps
// Usage:
//  Input channel is a queue write side: a vertex transaction is taken on a
//  clock edge with push high and full low. Results come out as a queue read
//  side: while empty is low the oldest result sits on the result ports and
//  is taken on an edge with pop high.
//  Config is a plain write port (cfg_wr_en, cfg_addr, cfg_wdata); the user
//  must write it only while no vertex is in flight; the block does not
//  enforce this. Unknown indexes are ignored. A vertex passes through 8
//  front stages (offset, three rotations as multiply then round,
//  numerators), one queue slot, then 28 back stages (abs, overflow check,
//  one quotient bit per stage over 24 stages, saturation, screen offset);
//  the first front stage loads on the accepting edge itself. Throughput
//  is one vertex per cycle with no stall, set by the fully pipelined
//  divider. A stalled receiver freezes the back pipe; the four entry queue
//  lets the front keep running until it fills, then full goes high.
//  Reset clears all valid bits and the queue and restores register defaults
//  (camera at origin, focal length 500, identity rotations).
module vertex_rotate_perspective_project (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic signed [23:0] vert_x,
    input  logic signed [23:0] vert_y,
    input  logic signed [23:0] vert_z,
    input  logic               last_in,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] screen_x,
    output logic signed [23:0] screen_y,
    output logic signed [23:0] depth,
    output logic               visible,
    output logic               last_out
);
    import vrp_pkg::*;

    vrp_entry_t push_data, pop_data;
    logic       q_push, q_full, q_pop, q_empty;

    vrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .vert_z    (vert_z),
        .last_in   (last_in),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    vrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    vrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .depth     (depth),
        .visible   (visible),
        .last_out  (last_out)
    );

endmodule
